// ----- hw/rtl/tile_block_unswizzle_address_assert.svh -----
// Assertion macros used by the checker file of the tile block unswizzle address block.
// No dependencies; take it in with an include of the bare file name.
`ifndef TILE_BLOCK_UNSWIZZLE_ADDRESS_ASSERT_SVH
`define TILE_BLOCK_UNSWIZZLE_ADDRESS_ASSERT_SVH
// same-cycle implication, masked while reset is asserted
`define TBUA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, masked while reset is asserted
`define TBUA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/tbua_pkg.sv -----
// Shared types and constants for the tile block unswizzle address block.
// No dependencies; used by the top level, the checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package tbua_pkg;

    localparam int MAX_TILES_ACROSS_DEF = 64;

    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int OFS_W   = 22;
    localparam int TILES_W = 7;

    // register stages from request to result
    localparam int PIPE_DEPTH = 6;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register indexes (paddr[2])
    localparam logic REG_TILES_ACROSS = 1'b0;
    localparam logic REG_BLOCK_KIND   = 1'b1;

    localparam logic KIND_BC1 = 1'b0;
    localparam logic KIND_BC7 = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0] src_col;
        logic [ROW_W-1:0] src_row;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] dest_col;
        logic [ROW_W-1:0] dest_row;
        logic [OFS_W-1:0] dest_offset;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/tbua_chan_if.sv -----
// Valid/ready channel interface carrying one payload struct per request.
// Payload type is a parameter; the block uses tbua_pkg::t_in_item and t_out_item.
`timescale 1ns / 1ps
`default_nettype none

interface tbua_chan_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- hw/rtl/tile_block_unswizzle_address.sv -----
// Tile block unswizzle address: stored-order block (col,row) -> linear (col,row,byte offset).
// Pipeline: 6 register stages, the last of which is the output register.
// Throughput: one request per cycle while o_rsp is ready; the restoring divide by the tile
//   count is split over two stages and the offset multiply has a stage of its own.
// Reset (i_rst_n low, synchronous): all stage valid bits clear, tiles_across = 1, BC1.
// Depends on tbua_pkg and tbua_chan_if.
`timescale 1ns / 1ps
`default_nettype none

module tile_block_unswizzle_address #(
    parameter int MAX_TILES_ACROSS = tbua_pkg::MAX_TILES_ACROSS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tbua_chan_if.sink                     i_req,
    tbua_chan_if.source                   o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbua_pkg::APB_AW-1:0]   paddr,
    input  logic [tbua_pkg::APB_DW-1:0]   pwdata,
    output logic [tbua_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Math in short. With t the effective tile count (W = 8t):
    //   p = col>>2, k = row>>1, y = p + 2t*row[0], z = y>>2
    //   qz = z / t, rz = z % t
    //   Q1 = k + qz, R1 = 4*rz + y[1:0]          (first stage, width W/2)
    //   R2 = rz + t*Q1[0]                        (second stage, width W/4)
    //   e  = (R2>>1) + t*Q1[1]                   (third stage, width W/8)
    //   drow = {Q1>>2, e[0], y[1], col[1]}
    //   dcol = {e>>1, R2[0], y[0], col[0]}
    //   offset = bytes * (drow*8t + dcol), truncated
    // The three chained unswizzles collapse to one small divide by t.
    // ------------------------------------------------------------------

    localparam int TW   = $clog2(MAX_TILES_ACROSS + 1);          // effective t
    localparam int PMAX = (1 << tbua_pkg::COL_W) / 4 - 1;        // largest col>>2
    localparam int YW   = $clog2(PMAX + 2 * MAX_TILES_ACROSS + 1);
    localparam int ZW   = YW - 2;                                // dividend bits
    localparam int ZLO  = ZW / 2;                                // bits done in stage 3
    localparam int ZHI  = ZW - ZLO;                              // bits done in stage 2
    localparam int KW   = tbua_pkg::ROW_W - 1;
    localparam int QW   = ((KW > ZW) ? KW : ZW) + 1;
    localparam int DRW  = QW + 1;                                // full dest row
    localparam int DCW  = TW + 3;                                // full dest col
    localparam int MW   = DRW + TW;                              // drow * t
    localparam int XW   = (((MW + 3) > DCW) ? (MW + 3) : DCW) + 1;
    localparam int NS   = tbua_pkg::PIPE_DEPTH;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tbua_pkg::TILES_W-1:0] r_tiles_across;   // as written, for readback
    logic [TW-1:0]                r_t;              // clamped to 1..MAX_TILES_ACROSS
    logic [TW-1:0]                n_t;
    logic                         r_kind;
    logic                         cfg_wr;
    logic                         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];

    // zero means one tile; too many saturates
    always_comb begin
        if (pwdata[tbua_pkg::TILES_W-1:0] == '0) begin
            n_t = TW'(1);
        end else if (32'(pwdata[tbua_pkg::TILES_W-1:0]) > 32'(MAX_TILES_ACROSS)) begin
            n_t = TW'(MAX_TILES_ACROSS);
        end else begin
            n_t = TW'(pwdata[tbua_pkg::TILES_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_across <= tbua_pkg::TILES_W'(1);
            r_t            <= TW'(1);
            r_kind         <= tbua_pkg::KIND_BC1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tbua_pkg::REG_TILES_ACROSS: begin
                    r_tiles_across <= pwdata[tbua_pkg::TILES_W-1:0];
                    r_t            <= n_t;
                end
                tbua_pkg::REG_BLOCK_KIND: begin
                    r_kind <= pwdata[0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            tbua_pkg::REG_TILES_ACROSS: prdata = tbua_pkg::APB_DW'(r_tiles_across);
            tbua_pkg::REG_BLOCK_KIND:   prdata = tbua_pkg::APB_DW'(r_kind);
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage takes a new request when it is
    // empty or its contents move on, so bubbles collapse under a stall.
    // ------------------------------------------------------------------
    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;
    logic [NS-1:0] vin;
    logic [NS-1:0] ld;

    always_comb begin
        rdy[NS] = o_rsp.ready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !r_vld[i] || rdy[i+1];
        end
    end

    assign vin         = {r_vld[NS-2:0], i_req.valid};
    assign ld          = vin & rdy[NS-1:0];
    assign i_req.ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: fold the row parity into the dividend.
    // ------------------------------------------------------------------
    logic [YW-1:0] r_s1_y;
    logic [KW-1:0] r_s1_k;
    logic [1:0]    r_s1_c;
    logic [YW-1:0] s1_y;

    assign s1_y = YW'(i_req.payload.src_col[tbua_pkg::COL_W-1:2])
                + (i_req.payload.src_row[0] ? YW'({r_t, 1'b0}) : '0);

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s1_y <= s1_y;
            r_s1_k <= i_req.payload.src_row[tbua_pkg::ROW_W-1:1];
            r_s1_c <= i_req.payload.src_col[1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: upper quotient bits of z / t, restoring, one bit per step.
    // ------------------------------------------------------------------
    logic [TW-1:0]  r_s2_rem;
    logic [ZHI-1:0] r_s2_qhi;
    logic [ZLO-1:0] r_s2_zlo;
    logic [1:0]     r_s2_ylo;
    logic [KW-1:0]  r_s2_k;
    logic [1:0]     r_s2_c;
    logic [TW-1:0]  s2_rem;
    logic [ZHI-1:0] s2_qhi;

    always_comb begin
        logic [TW:0]   trial;
        logic [TW-1:0] rem;
        logic [ZW-1:0] z;
        z      = r_s1_y[YW-1:2];
        rem    = '0;
        s2_qhi = '0;
        for (int i = ZHI - 1; i >= 0; i--) begin
            trial = {rem, z[ZLO+i]};
            if (trial >= {1'b0, r_t}) begin
                trial     = trial - {1'b0, r_t};
                s2_qhi[i] = 1'b1;
            end
            rem = trial[TW-1:0];
        end
        s2_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_s2_rem <= s2_rem;
            r_s2_qhi <= s2_qhi;
            r_s2_zlo <= r_s1_y[ZLO+1:2];
            r_s2_ylo <= r_s1_y[1:0];
            r_s2_k   <= r_s1_k;
            r_s2_c   <= r_s1_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: lower quotient bits; remainder rz is final here.
    // ------------------------------------------------------------------
    logic [ZW-1:0]  r_s3_qz;
    logic [TW-1:0]  r_s3_rz;
    logic [1:0]     r_s3_ylo;
    logic [KW-1:0]  r_s3_k;
    logic [1:0]     r_s3_c;
    logic [TW-1:0]  s3_rem;
    logic [ZLO-1:0] s3_qlo;

    always_comb begin
        logic [TW:0]   trial;
        logic [TW-1:0] rem;
        rem    = r_s2_rem;
        s3_qlo = '0;
        for (int i = ZLO - 1; i >= 0; i--) begin
            trial = {rem, r_s2_zlo[i]};
            if (trial >= {1'b0, r_t}) begin
                trial     = trial - {1'b0, r_t};
                s3_qlo[i] = 1'b1;
            end
            rem = trial[TW-1:0];
        end
        s3_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r_s3_qz  <= {r_s2_qhi, s3_qlo};
            r_s3_rz  <= s3_rem;
            r_s3_ylo <= r_s2_ylo;
            r_s3_k   <= r_s2_k;
            r_s3_c   <= r_s2_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: second and third unswizzle; both reduce to an add of t
    // picked by a quotient bit. Result bits are then just wired together.
    // ------------------------------------------------------------------
    logic [DRW-1:0] r_s4_drow;
    logic [DCW-1:0] r_s4_dcol;
    logic [QW-1:0]  s4_q1;
    logic [TW:0]    s4_r2;
    logic [TW:0]    s4_e;

    assign s4_q1 = QW'(r_s3_k) + QW'(r_s3_qz);
    assign s4_r2 = (TW + 1)'(r_s3_rz) + (s4_q1[0] ? {1'b0, r_t} : '0);
    assign s4_e  = {1'b0, s4_r2[TW:1]} + (s4_q1[1] ? {1'b0, r_t} : '0);

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r_s4_drow <= {s4_q1[QW-1:2], s4_e[0], r_s3_ylo[1], r_s3_c[1]};
            r_s4_dcol <= {s4_e[TW:1], s4_r2[0], r_s3_ylo[0], r_s3_c[0]};
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: drow * t (the *8 of the row width is a shift later).
    // ------------------------------------------------------------------
    logic [MW-1:0]  r_s5_mul;
    logic [DRW-1:0] r_s5_drow;
    logic [DCW-1:0] r_s5_dcol;

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r_s5_mul  <= MW'(r_s4_drow) * MW'(r_t);
            r_s5_drow <= r_s4_drow;
            r_s5_dcol <= r_s4_dcol;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: add the column, scale by block bytes, truncate to the
    // output fields. This is the output register.
    // ------------------------------------------------------------------
    tbua_pkg::t_out_item r_out;
    logic [XW-1:0]       s6_lin;
    logic [tbua_pkg::OFS_W-1:0] s6_ofs;

    assign s6_lin = XW'({r_s5_mul, 3'b000}) + XW'(r_s5_dcol);
    assign s6_ofs = (r_kind == tbua_pkg::KIND_BC7) ? tbua_pkg::OFS_W'({s6_lin, 4'b0000})
                                                   : tbua_pkg::OFS_W'({s6_lin, 3'b000});

    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r_out.dest_col    <= tbua_pkg::COL_W'(r_s5_dcol);
            r_out.dest_row    <= tbua_pkg::ROW_W'(r_s5_drow);
            r_out.dest_offset <= s6_ofs;
        end
    end

    assign o_rsp.valid   = r_vld[NS-1];
    assign o_rsp.payload = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/tbua_checker.sv -----
// Port-level checker for the tile block unswizzle address block, bound to the top level.
// Depends on tbua_pkg and tile_block_unswizzle_address_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tile_block_unswizzle_address_assert.svh"

module tbua_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  tbua_pkg::t_out_item         i_out_item,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [tbua_pkg::APB_AW-1:0] i_paddr,
    input  logic [tbua_pkg::APB_DW-1:0] i_pwdata
);

    localparam int CNT_W = $clog2(tbua_pkg::PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;     // requests in flight
    logic             r_kind;    // mirror of block_kind

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_kind <= tbua_pkg::KIND_BC1;
        end else begin
            r_cnt <= r_cnt + CNT_W'(i_in_valid && i_in_ready)
                           - CNT_W'(i_out_valid && i_out_ready);
            if (i_psel && i_penable && i_pwrite && (i_paddr[2] == tbua_pkg::REG_BLOCK_KIND)) begin
                r_kind <= i_pwdata[0];
            end
        end
    end

    `TBUA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item), "result dropped or changed while stalled")
    `TBUA_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, (r_cnt == CNT_W'(tbua_pkg::PIPE_DEPTH)) && !i_out_ready, !i_in_ready, "request taken with every stage full")
    `TBUA_ASSERT_IMPL(a_no_phantom, i_clk, i_rst_n, i_out_valid, r_cnt != '0, "result without a request in flight")
    `TBUA_ASSERT_IMPL(a_ofs_align, i_clk, i_rst_n, i_out_valid, (i_out_item.dest_offset[2:0] == 3'b000) && (!r_kind || !i_out_item.dest_offset[3]), "offset not aligned to block size")

endmodule

bind tile_block_unswizzle_address tbua_checker u_tbua_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_item  (o_rsp.payload),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking bench for tile_block_unswizzle_address: directed vectors, then random phases.
// Depends on tbua_pkg and tbua_chan_if; drives the request channel and the register port.
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES  = 64;    // receiver hold-off that backs the pipe up
    localparam int STALL_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int PHASE_ITEMS  = 80;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_DIRECTED = 18;

    // one directed vector: register setting, request, and an optional hand-typed answer
    typedef struct {
        logic [tbua_pkg::TILES_W-1:0] tiles;
        logic                         kind;
        logic [tbua_pkg::COL_W-1:0]   col;
        logic [tbua_pkg::ROW_W-1:0]   row;
        bit                           typed;
        tbua_pkg::t_out_item          answer;
    } t_vector;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [tbua_pkg::APB_AW-1:0] paddr;
    logic [tbua_pkg::APB_DW-1:0] pwdata;
    logic [tbua_pkg::APB_DW-1:0] prdata;
    logic pready;

    tbua_chan_if #(.t_payload(tbua_pkg::t_in_item))  req_if ();
    tbua_chan_if #(.t_payload(tbua_pkg::t_out_item)) rsp_if ();

    tile_block_unswizzle_address i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the register file, updated after each write lands
    logic [tbua_pkg::TILES_W-1:0] cfg_tiles;
    logic                         cfg_kind;

    tbua_pkg::t_out_item expected_addrs[$];   // predicted results, oldest first

    int  err_count;
    int  requests_sent;
    int  addrs_checked;
    int  settings_used;
    int  input_stall_cycles;
    bit  no_idle;        // both sides run flat out while set
    bit  hold_off_req;   // main asks the receiver for one long hold-off

    t_vector directed_vec [0:NUM_DIRECTED-1] = '{
        // reset setting: origin and first column are obvious
        '{7'd1,   tbua_pkg::KIND_BC1, 9'd0,   9'd0,   1'b1, '{9'd0, 9'd0, 22'd0}},
        '{7'd1,   tbua_pkg::KIND_BC1, 9'd1,   9'd0,   1'b1, '{9'd1, 9'd0, 22'd8}},
        '{7'd1,   tbua_pkg::KIND_BC1, 9'd7,   9'd3,   1'b0, '{9'd0, 9'd0, 22'd0}},
        // column past the row width
        '{7'd1,   tbua_pkg::KIND_BC1, 9'd8,   9'd0,   1'b0, '{9'd0, 9'd0, 22'd0}},
        '{7'd1,   tbua_pkg::KIND_BC1, 9'd511, 9'd511, 1'b0, '{9'd0, 9'd0, 22'd0}},
        // 16-byte blocks double the offset
        '{7'd1,   tbua_pkg::KIND_BC7, 9'd1,   9'd0,   1'b1, '{9'd1, 9'd0, 22'd16}},
        '{7'd1,   tbua_pkg::KIND_BC7, 9'h155, 9'h0AA, 1'b0, '{9'd0, 9'd0, 22'd0}},
        // zero tile count behaves as one tile
        '{7'd0,   tbua_pkg::KIND_BC7, 9'd1,   9'd0,   1'b1, '{9'd1, 9'd0, 22'd16}},
        '{7'd0,   tbua_pkg::KIND_BC1, 9'h0AA, 9'h155, 1'b0, '{9'd0, 9'd0, 22'd0}},
        // widest legal texture
        '{7'd64,  tbua_pkg::KIND_BC1, 9'd0,   9'd0,   1'b1, '{9'd0, 9'd0, 22'd0}},
        '{7'd64,  tbua_pkg::KIND_BC1, 9'd511, 9'd0,   1'b0, '{9'd0, 9'd0, 22'd0}},
        '{7'd64,  tbua_pkg::KIND_BC1, 9'd511, 9'd511, 1'b0, '{9'd0, 9'd0, 22'd0}},
        '{7'd64,  tbua_pkg::KIND_BC7, 9'd300, 9'd200, 1'b0, '{9'd0, 9'd0, 22'd0}},
        // tile count above the maximum saturates
        '{7'd127, tbua_pkg::KIND_BC7, 9'd511, 9'd511, 1'b0, '{9'd0, 9'd0, 22'd0}},
        '{7'd65,  tbua_pkg::KIND_BC1, 9'd256, 9'd100, 1'b0, '{9'd0, 9'd0, 22'd0}},
        '{7'd127, tbua_pkg::KIND_BC1, 9'd0,   9'd0,   1'b1, '{9'd0, 9'd0, 22'd0}},
        // odd tile count
        '{7'd3,   tbua_pkg::KIND_BC7, 9'd23,  9'd5,   1'b0, '{9'd0, 9'd0, 22'd0}},
        '{7'd3,   tbua_pkg::KIND_BC1, 9'd24,  9'd1,   1'b0, '{9'd0, 9'd0, 22'd0}}
    };

    // ------------------------------------------------------------------
    // Address predictor
    // ------------------------------------------------------------------

    // one interleave step over linear index v, half-width of half blocks
    function automatic int unsigned interleave_step(int unsigned v, int unsigned half);
        int unsigned span;
        int unsigned r;
        span = 2 * half;
        r    = v % span;
        return r / 2 + half * (r % 2) + span * (v / span);
    endfunction

    function automatic tbua_pkg::t_out_item unswizzle_block(tbua_pkg::t_in_item it,
                                                            logic [tbua_pkg::TILES_W-1:0] tiles,
                                                            logic kind);
        int unsigned t, w, n2, n4, n8;
        int unsigned col, row;
        int unsigned b2, c2f, mx1, my1, c2;
        int unsigned b4, c4f, my2, c4;
        int unsigned tt, b8, dcol, drow;
        longint unsigned offset;
        tbua_pkg::t_out_item res;
        t   = 32'(tiles);
        col = 32'(it.src_col);
        row = 32'(it.src_row);
        if (t == 0) t = 1;
        if (t > tbua_pkg::MAX_TILES_ACROSS_DEF) t = tbua_pkg::MAX_TILES_ACROSS_DEF;
        w  = 8 * t;
        n2 = w / 2;
        n4 = w / 4;
        n8 = w / 8;
        // W/2 stage
        b2  = interleave_step(col / 2 + row * n2, n2);
        c2f = col % 2 + 2 * (b2 % n2);
        mx1 = b2 / n2;
        my1 = c2f / 4;
        c2  = c2f % 4;
        // W/4 stage
        b4  = interleave_step(my1 + (mx1 / 2) * n4, n4);
        c4f = mx1 % 2 + 2 * (b4 / n4);
        my2 = c4f / 4;
        c4  = c4f % 4;
        // W/8 stage
        tt   = c2 + 4 * (b4 % n4);
        b8   = interleave_step(tt / 8 + my2 * n8, n8);
        drow = c4 + 4 * (b8 / n8);
        dcol = tt % 8 + 8 * (b8 % n8);
        offset = (kind == tbua_pkg::KIND_BC7 ? 64'd16 : 64'd8)
                 * (64'(drow) * 64'(w) + 64'(dcol));
        res.dest_col    = dcol[tbua_pkg::COL_W-1:0];
        res.dest_row    = drow[tbua_pkg::ROW_W-1:0];
        res.dest_offset = offset[tbua_pkg::OFS_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, receiver, result checker, watchdog
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, or one long hold-off on request.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 30);
            end
        end
    end

    // Each accepted result is matched against the oldest prediction.
    always @(posedge i_clk) begin
        tbua_pkg::t_out_item want;
        tbua_pkg::t_out_item got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_addrs.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected result col=%0d row=%0d ofs=%0d",
                             $realtime, got.dest_col, got.dest_row, got.dest_offset);
            end else begin
                want = expected_addrs.pop_front();
                addrs_checked++;
                if (got.dest_col !== want.dest_col || got.dest_row !== want.dest_row ||
                    got.dest_offset !== want.dest_offset) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"%0t: result %0d exp col=%0d row=%0d ofs=%0d, ",
                                  "got col=%0d row=%0d ofs=%0d"},
                                 $realtime, addrs_checked, want.dest_col, want.dest_row,
                                 want.dest_offset, got.dest_col, got.dest_row,
                                 got.dest_offset);
                end
            end
        end
        if (req_if.valid && !req_if.ready) input_stall_cycles++;
    end

    // Watchdog: any transfer on either channel or the register port resets the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel ||
                !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("tile_block_unswizzle_address: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus tasks (all called right after a rising edge)
    // ------------------------------------------------------------------

    // setup then access phase; write lands on the edge with pready high,
    // then the bus returns to idle
    task automatic write_register(logic reg_index, logic [tbua_pkg::APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_index == tbua_pkg::REG_TILES_ACROSS) cfg_tiles = value[tbua_pkg::TILES_W-1:0];
        else cfg_kind = value[0];
        @(posedge i_clk);
    endtask

    // drop valid and wait until every predicted result has been seen
    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_addrs.size() != 0) @(posedge i_clk);
    endtask

    // change the setting only when it differs; the pipe is drained first
    task automatic apply_setting(logic [tbua_pkg::TILES_W-1:0] tiles, logic kind);
        if (tiles !== cfg_tiles || kind !== cfg_kind) begin
            drain_results();
            if (tiles !== cfg_tiles)
                write_register(tbua_pkg::REG_TILES_ACROSS, tbua_pkg::APB_DW'(tiles));
            if (kind !== cfg_kind)
                write_register(tbua_pkg::REG_BLOCK_KIND, tbua_pkg::APB_DW'(kind));
            settings_used++;
        end
    endtask

    // offer one request, optionally after a random gap; record its expected address
    task automatic send_request(tbua_pkg::t_in_item it, bit typed,
                                tbua_pkg::t_out_item answer);
        if (!no_idle) begin
            while ($urandom_range(99) < 30) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= it;
        do @(posedge i_clk); while (!req_if.ready);
        expected_addrs.push_back(typed ? answer : unswizzle_block(it, cfg_tiles, cfg_kind));
        requests_sent++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        tbua_pkg::t_in_item  it;
        tbua_pkg::t_out_item none;
        int unsigned t_eff;
        int unsigned row_w;
        logic [tbua_pkg::TILES_W-1:0] ph_tiles;
        logic ph_kind;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        no_idle        = 1'b0;
        hold_off_req   = 1'b0;
        err_count      = 0;
        requests_sent  = 0;
        addrs_checked  = 0;
        settings_used  = 1;
        input_stall_cycles = 0;
        none           = '0;
        // values after reset
        cfg_tiles      = 7'd1;
        cfg_kind       = tbua_pkg::KIND_BC1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed vectors: origin, extremes, width clamping, both block kinds
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            apply_setting(directed_vec[i].tiles, directed_vec[i].kind);
            it.src_col = directed_vec[i].col;
            it.src_row = directed_vec[i].row;
            send_request(it, directed_vec[i].typed, directed_vec[i].answer);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            unique case (ph)
                0: begin ph_tiles = 7'd1;  ph_kind = tbua_pkg::KIND_BC1; end
                1: begin ph_tiles = 7'd64; ph_kind = tbua_pkg::KIND_BC7; end
                2: begin ph_tiles = 7'($urandom_range(63, 2)); ph_kind = tbua_pkg::KIND_BC1; end
                3: begin ph_tiles = 7'($urandom_range(127, 65)); ph_kind = 1'($urandom); end
                4: begin ph_tiles = 7'd0;  ph_kind = tbua_pkg::KIND_BC7; end
                default: begin
                    ph_tiles = 7'($urandom_range(64, 1));
                    ph_kind  = 1'($urandom);
                end
            endcase
            apply_setting(ph_tiles, ph_kind);
            no_idle = (ph == 0);   // first phase runs with no gaps on either side
            t_eff = (ph_tiles == 0) ? 1 : (32'(ph_tiles) > tbua_pkg::MAX_TILES_ACROSS_DEF) ?
                    tbua_pkg::MAX_TILES_ACROSS_DEF : 32'(ph_tiles);
            row_w = 8 * t_eff;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver holds off while the sender keeps pushing: pipe fills
                if (ph == 1 && n == 10) hold_off_req = 1'b1;
                // sender pauses until the pipe is empty
                if (ph == 2 && n == 40) drain_results();
                // mostly columns inside the row, some past it
                if ($urandom_range(99) < 85)
                    it.src_col = tbua_pkg::COL_W'($urandom_range(row_w - 1));
                else
                    it.src_col = tbua_pkg::COL_W'($urandom_range(511));
                it.src_row = tbua_pkg::ROW_W'($urandom_range(511));
                send_request(it, 1'b0, none);
            end
        end

        no_idle = 1'b0;
        drain_results();
        // catch any stray result after the last one
        repeat (4 * tbua_pkg::PIPE_DEPTH) @(posedge i_clk);

        $display("%0d requests, %0d addresses checked across %0d register settings",
                 requests_sent, addrs_checked, settings_used);
        $display("input back-pressure seen for %0d cycles; %0d errors",
                 input_stall_cycles, err_count);
        if (err_count == 0 && expected_addrs.size() == 0) begin
            $display("tile_block_unswizzle_address: match");
        end else begin
            if (expected_addrs.size() != 0)
                $display("%0d expected results never arrived", expected_addrs.size());
            $display("tile_block_unswizzle_address: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tbua_pkg.sv
hw/rtl/tbua_chan_if.sv
hw/rtl/tile_block_unswizzle_address.sv
hw/rtl/tbua_checker.sv
tb/sv/testbench.sv
